// ===== sv/mcid_pkg.sv =====
// Shared constants and types for the multi-channel input debouncer.
package mcid_pkg;

	// Number of debounced channels; the data fields carry at most FIELD_W of them
	localparam int CHANNELS = 16;
	localparam int FIELD_W  = 16;
	localparam int LANES    = (CHANNELS < FIELD_W) ? CHANNELS : FIELD_W;

	// Mismatch counter: 17 bits, saturating at all ones
	localparam int                 CNT_W   = 17;
	localparam logic [CNT_W-1:0]   CNT_MAX = {CNT_W{1'b1}};

	// Configuration port geometry
	localparam int ADDR_W = 4;
	localparam int DATA_W = 32;

	// Register reset values
	localparam logic [FIELD_W-1:0] RISE_RST   = '0;
	localparam logic [FIELD_W-1:0] FALL_RST   = '0;
	localparam logic [FIELD_W-1:0] INVERT_RST = '0;
	localparam logic [FIELD_W-1:0] ENABLE_RST = {FIELD_W{1'b1}};

	// Register indexes (byte address / 4)
	typedef enum logic [1:0] {
		REG_RISE   = 2'd0,
		REG_FALL   = 2'd1,
		REG_INVERT = 2'd2,
		REG_ENABLE = 2'd3
	} reg_idx_t;

	// Configuration as seen by the datapath
	typedef struct packed {
		logic [FIELD_W-1:0] rise_count;
		logic [FIELD_W-1:0] fall_count;
		logic [FIELD_W-1:0] invert_mask;
		logic [FIELD_W-1:0] enable_mask;
	} cfg_t;

	// One result word
	typedef struct packed {
		logic [FIELD_W-1:0] level_bits;
		logic [FIELD_W-1:0] changed_bits;
	} result_t;

endpackage

// ===== sv/mcid_regs.sv =====
// APB-style configuration registers of the debouncer.
module mcid_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [mcid_pkg::ADDR_W-1:0] paddr,
	input  logic [mcid_pkg::DATA_W-1:0] pwdata,
	output logic [mcid_pkg::DATA_W-1:0] prdata,
	output logic                        pready,
	output mcid_pkg::cfg_t              cfg
);
	import mcid_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.rise_count  <= RISE_RST;
			cfg_q.fall_count  <= FALL_RST;
			cfg_q.invert_mask <= INVERT_RST;
			cfg_q.enable_mask <= ENABLE_RST;
		end else if (wr_en) begin
			case (idx)
				REG_RISE:   cfg_q.rise_count  <= pwdata[FIELD_W-1:0];
				REG_FALL:   cfg_q.fall_count  <= pwdata[FIELD_W-1:0];
				REG_INVERT: cfg_q.invert_mask <= pwdata[FIELD_W-1:0];
				REG_ENABLE: cfg_q.enable_mask <= pwdata[FIELD_W-1:0];
				default: ;
			endcase
		end
	end

	// read mux
	always_comb begin
		prdata = '0;
		case (idx)
			REG_RISE:   prdata[FIELD_W-1:0] = cfg_q.rise_count;
			REG_FALL:   prdata[FIELD_W-1:0] = cfg_q.fall_count;
			REG_INVERT: prdata[FIELD_W-1:0] = cfg_q.invert_mask;
			REG_ENABLE: prdata[FIELD_W-1:0] = cfg_q.enable_mask;
			default:    prdata = '0;
		endcase
	end

endmodule

// ===== sv/mcid_lane.sv =====
// One debounce channel: accepted level and saturating mismatch counter.
module mcid_lane (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         advance,
	input  logic                         enable,
	input  logic                         sample,
	input  logic [mcid_pkg::FIELD_W-1:0] rise_count,
	input  logic [mcid_pkg::FIELD_W-1:0] fall_count,
	output logic                         level_next,
	output logic                         changed
);
	import mcid_pkg::*;

	logic               level_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [CNT_W-1:0]   cnt_inc;
	logic [CNT_W-1:0]   cnt_next;
	logic [FIELD_W-1:0] limit;
	logic               mismatch;

	// next state of this channel for the current word
	always_comb begin
		mismatch   = enable && (sample != level_q);
		limit      = level_q ? fall_count : rise_count;
		cnt_inc    = (cnt_q == CNT_MAX) ? cnt_q : cnt_q + 1'b1;
		changed    = mismatch && (cnt_inc > {1'b0, limit});
		level_next = changed ? sample : level_q;
		if (!enable) begin
			cnt_next = cnt_q;
		end else if (!mismatch || changed) begin
			cnt_next = '0;
		end else begin
			cnt_next = cnt_inc;
		end
	end

	// state update on each accepted word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q <= 1'b0;
			cnt_q   <= '0;
		end else if (advance) begin
			level_q <= level_next;
			cnt_q   <= cnt_next;
		end
	end

endmodule

// ===== sv/mcid_merge.sv =====
// Gathers lane results into one word and holds it in a two-entry output buffer.
module mcid_merge (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	input  logic [mcid_pkg::FIELD_W-1:0] lane_levels,
	input  logic [mcid_pkg::FIELD_W-1:0] lane_changed,
	input  logic [mcid_pkg::FIELD_W-1:0] invert_mask,
	output logic                         space,
	output logic                         out_valid,
	input  logic                         out_ready,
	output mcid_pkg::result_t            result
);
	import mcid_pkg::*;

	result_t new_word;
	result_t main_q;
	result_t skid_q;
	logic    main_valid_q;
	logic    skid_valid_q;
	logic    pop;

	// polarity correction at merge time
	assign new_word.level_bits   = lane_levels ^ invert_mask;
	assign new_word.changed_bits = lane_changed;

	assign pop       = main_valid_q && out_ready;
	assign space     = !skid_valid_q;
	assign out_valid = main_valid_q;
	assign result    = main_q;

	// buffer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (!main_valid_q) begin
				main_valid_q <= push;
			end else if (pop) begin
				main_valid_q <= skid_valid_q || push;
				skid_valid_q <= skid_valid_q && push;
			end else if (push) begin
				skid_valid_q <= 1'b1;
			end
		end
	end

	// buffer payload
	always_ff @(posedge clk) begin
		if (!main_valid_q || pop) begin
			if (skid_valid_q) begin
				main_q <= skid_q;
			end else if (push) begin
				main_q <= new_word;
			end
		end
		if (push && main_valid_q && (!pop || skid_valid_q)) begin
			skid_q <= new_word;
		end
	end

endmodule

// ===== sv/multi_channel_input_debouncer_top.sv =====
// Top level of the multi-channel input debouncer.
//
//  channel   handshake            payload
//  input     in_valid/in_ready    raw_levels
//  output    out_valid/out_ready  level_bits, changed_bits
//  config    APB psel/penable     paddr, pwdata, prdata
//
// One word per clock while in_ready is high: every channel lane updates
// its level and counter in the cycle the word is accepted.
// A two-entry output buffer keeps input open for one word while a result
// waits; in_ready drops only when both entries are full.
// Reset clears levels, counters and registers at once; no clearing pass.
module multi_channel_input_debouncer_top (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [mcid_pkg::ADDR_W-1:0]  paddr,
	input  logic [mcid_pkg::DATA_W-1:0]  pwdata,
	output logic [mcid_pkg::DATA_W-1:0]  prdata,
	output logic                         pready,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [mcid_pkg::FIELD_W-1:0] raw_levels,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [mcid_pkg::FIELD_W-1:0] level_bits,
	output logic [mcid_pkg::FIELD_W-1:0] changed_bits
);
	import mcid_pkg::*;

	cfg_t               cfg;
	result_t            result;
	logic               push;
	logic [FIELD_W-1:0] lane_levels;
	logic [FIELD_W-1:0] lane_changed;

	assign push = in_valid && in_ready;

	mcid_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// one lane per channel; field bits with no channel read as level zero
	for (genvar i = 0; i < FIELD_W; i++) begin : g_lane
		if (i < LANES) begin : g_on
			mcid_lane u_lane (
				.clk        (clk),
				.arst_n     (arst_n),
				.advance    (push),
				.enable     (cfg.enable_mask[i]),
				.sample     (raw_levels[i]),
				.rise_count (cfg.rise_count),
				.fall_count (cfg.fall_count),
				.level_next (lane_levels[i]),
				.changed    (lane_changed[i])
			);
		end else begin : g_off
			assign lane_levels[i]  = 1'b0;
			assign lane_changed[i] = 1'b0;
		end
	end

	mcid_merge u_merge (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.lane_levels  (lane_levels),
		.lane_changed (lane_changed),
		.invert_mask  (cfg.invert_mask),
		.space        (in_ready),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.result       (result)
	);

	assign level_bits   = result.level_bits;
	assign changed_bits = result.changed_bits;

endmodule

// ===== sv/mcid_check.sv =====
// Port-level checks of the debouncer, bound to its top level.
module mcid_check (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_valid,
	input logic                         in_ready,
	input logic                         out_valid,
	input logic                         out_ready,
	input logic [mcid_pkg::FIELD_W-1:0] level_bits,
	input logic [mcid_pkg::FIELD_W-1:0] changed_bits
);

	// a stalled result holds its word
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(level_bits) && $stable(changed_bits))
		else $error("result word changed while stalled");

	// a word accepted into an empty buffer shows up next cycle
	a_in_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && !out_valid |=> out_valid)
		else $error("accepted word did not reach the output");

	// input closes only when a result is waiting
	a_full_has_out: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("input closed with no result pending");

	// a full buffer stays full until a result is taken
	a_full_stays: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready && !out_ready |=> !in_ready)
		else $error("buffer drained without a result being taken");

endmodule

bind multi_channel_input_debouncer_top mcid_check u_check (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_ready     (in_ready),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.level_bits   (level_bits),
	.changed_bits (changed_bits)
);
